// ===== design/lfsp_pkg.sv =====
// ============================================================================
// lfsp_pkg
// Shared widths, register indexes, result modes, multiplier step codes and
// the control and configuration bundles of the line-follow steering PID unit.
// ============================================================================
`default_nettype none

package lfsp_pkg;

    // Field widths
    localparam int SENSE_W  = 10;
    localparam int SPEED_W  = 8;
    localparam int MODE_W   = 2;
    localparam int KI_W     = 20;
    localparam int ERR_W    = 11;
    localparam int DERR_W   = 12;
    localparam int SUM_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Datapath widths
    localparam int OPND_W  = 25;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 48;
    localparam int KP_W    = 21;
    localparam int KD_W    = 24;
    localparam int Q_SHIFT = 20;
    localparam int PID_W   = ACC_W - Q_SHIFT;
    localparam int STEP_W  = 3;

    // Controller constants
    localparam logic [SENSE_W-1:0] FULL_SCALE = 10'd1000;
    localparam logic [9:0]         KP_SCALE   = 10'd629;
    localparam logic [3:0]         KD_FACTOR  = 4'd10;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 8'd255;

    // Register reset values
    localparam logic [SENSE_W-1:0] THR_RESET  = 10'd500;
    localparam logic [SPEED_W-1:0] BASE_RESET = 8'd200;
    localparam logic [KI_W-1:0]    KI_RESET   = 20'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR_FAR_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MID_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_MID_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FAR_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN       = 3'd5;

    // Result modes
    localparam logic [MODE_W-1:0] MODE_EXT_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXT_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD      = 2'd3;

    // Multiplier steps
    localparam logic [STEP_W-1:0] STEP_KP    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_KD    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_P     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_I     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_D     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

    typedef struct packed {
        logic [SENSE_W-1:0] thr_far_left;
        logic [SENSE_W-1:0] thr_mid_left;
        logic [SENSE_W-1:0] thr_mid_right;
        logic [SENSE_W-1:0] thr_far_right;
        logic [SPEED_W-1:0] base_speed;
        logic [KI_W-1:0]    ki_gain;
    } t_cfg;

    typedef struct packed {
        logic              run;
        logic [STEP_W-1:0] step;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ===== design/line_follow_steering_pid_unit.sv =====
// ============================================================================
// line_follow_steering_pid_unit
// Line-follow steering controller: six reflectance samples in, left and
// right motor speeds and a steering mode out, with PID on the left-right error.
// ============================================================================
// Usage:
// One input beat on i_in_valid/o_in_ready carries the six samples; one
// output beat on o_out_valid/i_out_ready carries the two speeds and the
// mode. Registers are written on the i_cfg_valid/o_cfg_ready channel, which
// is always ready; write them only while the unit is idle.
// An extreme-turn or hold beat goes from the decide state straight to
// the done state; a forward PID beat first has the shared multiplier run
// six steps (kp, kd, the three PID terms, final add) followed by a rounding
// and a clamping step. The unit takes a new beat in the cycle after its
// result is loaded, so it never works on more than one beat at a time.
// The result sits in an output register, so the next beat can be accepted
// while the receiver stalls; a finished result waits until that register
// frees up. Reset clears the PID state and the held speeds to zero, loads
// the register defaults and empties the output register.
// ============================================================================
`default_nettype none

module line_follow_steering_pid_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input samples
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_far_left,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_left,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_mid_left,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_mid_right,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_right,
    input  wire logic [lfsp_pkg::SENSE_W-1:0]       i_sense_far_right,
    // Results
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [lfsp_pkg::SPEED_W-1:0]       o_left_speed,
    output logic      [lfsp_pkg::SPEED_W-1:0]       o_right_speed,
    output logic      [lfsp_pkg::MODE_W-1:0]        o_steer_mode,
    // Configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lfsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lfsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW   = lfsp_pkg::SENSE_W;
    localparam int SPW  = lfsp_pkg::SPEED_W;
    localparam int PW   = lfsp_pkg::PID_W;
    localparam int SUMW = lfsp_pkg::SUM_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_SPEED  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    lfsp_pkg::t_cfg      w_cfg;
    lfsp_pkg::t_mac_ctrl w_mac_ctrl;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [lfsp_pkg::STEP_W-1:0] r_step;

    // Latched samples
    logic [SW-1:0] r_s_far_left;
    logic [SW-1:0] r_s_left;
    logic [SW-1:0] r_s_mid_left;
    logic [SW-1:0] r_s_mid_right;
    logic [SW-1:0] r_s_right;
    logic [SW-1:0] r_s_far_right;

    // PID state and working values
    logic signed [lfsp_pkg::ERR_W-1:0]  r_last_err;
    logic signed [SUMW-1:0]             r_err_sum;
    logic signed [lfsp_pkg::DERR_W-1:0] r_derr;
    logic        [SW-1:0]               r_avg;
    logic signed [PW-1:0]               r_pid;

    // Pending result and output register
    logic [SPW-1:0]              r_res_left;
    logic [SPW-1:0]              r_res_right;
    logic [lfsp_pkg::MODE_W-1:0] r_res_mode;
    logic                        r_out_valid;
    logic [SPW-1:0]              r_out_left;
    logic [SPW-1:0]              r_out_right;
    logic [lfsp_pkg::MODE_W-1:0] r_out_mode;

    logic                              w_in_fire;
    logic                              w_ext_left;
    logic                              w_ext_right;
    logic                              w_forward;
    logic [SW:0]                       w_mid_sum;
    logic [SW:0]                       w_thr_sum;
    logic signed [lfsp_pkg::ERR_W-1:0] w_err;
    logic signed [SUMW:0]              w_sum_wide;
    logic signed [SUMW-1:0]            w_sum_sat;
    logic signed [lfsp_pkg::ACC_W-1:0] w_acc;
    logic signed [PW-1:0]              w_pid;
    logic signed [PW:0]                w_left_raw;
    logic signed [PW:0]                w_right_raw;
    logic                              w_out_free;

    // Clamp a signed speed into 0..255.
    function automatic logic [SPW-1:0] clamp_speed(input logic signed [PW:0] v);
        logic [SPW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(PW+1-SPW){1'b0}}, lfsp_pkg::SPEED_MAX})) begin
            res = lfsp_pkg::SPEED_MAX;
        end else begin
            res = v[SPW-1:0];
        end
        return res;
    endfunction

    lfsp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Steering decision on the latched samples.
    assign w_mid_sum   = {1'b0, r_s_mid_left} + {1'b0, r_s_mid_right};
    assign w_thr_sum   = {1'b0, w_cfg.thr_mid_left} + {1'b0, w_cfg.thr_mid_right};
    assign w_ext_left  = (r_s_far_left > w_cfg.thr_far_left) &&
                         (r_s_far_right < w_cfg.thr_far_right);
    assign w_ext_right = (r_s_far_left < w_cfg.thr_far_left) &&
                         (r_s_far_right > w_cfg.thr_far_right);
    assign w_forward   = w_mid_sum[SW:1] > w_thr_sum[SW:1];

    // Error and saturating integral.
    assign w_err      = $signed({1'b0, r_s_left} - {1'b0, r_s_right});
    assign w_sum_wide = {r_err_sum[SUMW-1], r_err_sum} +
                        {{(SUMW+1-lfsp_pkg::ERR_W){w_err[lfsp_pkg::ERR_W-1]}}, w_err};
    always_comb begin
        if (w_sum_wide[SUMW] == w_sum_wide[SUMW-1]) begin
            w_sum_sat = w_sum_wide[SUMW-1:0];
        end else if (w_sum_wide[SUMW]) begin
            w_sum_sat = {1'b1, {(SUMW-1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(SUMW-1){1'b1}}};
        end
    end

    assign w_mac_ctrl = '{run: (r_state == ST_MAC), step: r_step};

    lfsp_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_mac_ctrl),
        .i_avg     (r_avg),
        .i_err     (r_last_err),
        .i_derr    (r_derr),
        .i_err_sum (r_err_sum),
        .i_ki      (w_cfg.ki_gain),
        .o_acc     (w_acc)
    );

    // Divide by 2^20 with truncation toward zero.
    assign w_pid = w_acc[lfsp_pkg::ACC_W-1:lfsp_pkg::Q_SHIFT] +
                   PW'(w_acc[lfsp_pkg::ACC_W-1] && (|w_acc[lfsp_pkg::Q_SHIFT-1:0]));

    assign w_left_raw  = $signed({{(PW+1-SPW){1'b0}}, w_cfg.base_speed}) +
                         {r_pid[PW-1], r_pid};
    assign w_right_raw = $signed({{(PW+1-SPW){1'b0}}, w_cfg.base_speed}) -
                         {r_pid[PW-1], r_pid};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!w_ext_left && !w_ext_right && w_forward) begin
                    n_state = ST_MAC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MAC: begin
                if (r_step == lfsp_pkg::STEP_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_SPEED;
            end
            ST_SPEED: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, PID state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= lfsp_pkg::STEP_KP;
            r_last_err  <= '0;
            r_err_sum   <= '0;
            r_out_valid <= 1'b0;
            r_out_left  <= '0;
            r_out_right <= '0;
            r_out_mode  <= lfsp_pkg::MODE_HOLD;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MAC) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= lfsp_pkg::STEP_KP;
            end
            if (r_state == ST_DECIDE && !w_ext_left && !w_ext_right && w_forward) begin
                r_last_err <= w_err;
                r_err_sum  <= w_sum_sat;
            end
            // The output register also keeps the held speeds.
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_left  <= r_res_left;
                r_out_right <= r_res_right;
                r_out_mode  <= r_res_mode;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample latch and datapath working registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s_far_left  <= i_sense_far_left;
            r_s_left      <= i_sense_left;
            r_s_mid_left  <= i_sense_mid_left;
            r_s_mid_right <= i_sense_mid_right;
            r_s_right     <= i_sense_right;
            r_s_far_right <= i_sense_far_right;
        end
        if (r_state == ST_DECIDE) begin
            r_avg  <= w_mid_sum[SW:1];
            r_derr <= {w_err[lfsp_pkg::ERR_W-1], w_err} -
                      {r_last_err[lfsp_pkg::ERR_W-1], r_last_err};
            if (w_ext_left) begin
                r_res_left  <= '0;
                r_res_right <= w_cfg.base_speed;
                r_res_mode  <= lfsp_pkg::MODE_EXT_LEFT;
            end else if (w_ext_right) begin
                r_res_left  <= w_cfg.base_speed;
                r_res_right <= '0;
                r_res_mode  <= lfsp_pkg::MODE_EXT_RIGHT;
            end else begin
                r_res_left  <= r_out_left;
                r_res_right <= r_out_right;
                r_res_mode  <= w_forward ? lfsp_pkg::MODE_FORWARD : lfsp_pkg::MODE_HOLD;
            end
        end
        if (r_state == ST_ROUND) begin
            r_pid <= w_pid;
        end
        if (r_state == ST_SPEED) begin
            r_res_left  <= clamp_speed(w_left_raw);
            r_res_right <= clamp_speed(w_right_raw);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_speed  = r_out_left;
    assign o_right_speed = r_out_right;
    assign o_steer_mode  = r_out_mode;

endmodule

`default_nettype wire

// ===== design/lfsp_cfg_regs.sv =====
// ============================================================================
// lfsp_cfg_regs
// Configuration register file: thresholds, base speed and integral gain,
// written one register per beat on the configuration channel.
// ============================================================================
`default_nettype none

module lfsp_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_wr_en,
    input  wire logic [lfsp_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  wire logic [lfsp_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output lfsp_pkg::t_cfg                          o_cfg
);

    lfsp_pkg::t_cfg r_cfg;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_far_left  <= lfsp_pkg::THR_RESET;
            r_cfg.thr_mid_left  <= lfsp_pkg::THR_RESET;
            r_cfg.thr_mid_right <= lfsp_pkg::THR_RESET;
            r_cfg.thr_far_right <= lfsp_pkg::THR_RESET;
            r_cfg.base_speed    <= lfsp_pkg::BASE_RESET;
            r_cfg.ki_gain       <= lfsp_pkg::KI_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                lfsp_pkg::REG_THR_FAR_LEFT: begin
                    r_cfg.thr_far_left <= i_wr_data[lfsp_pkg::SENSE_W-1:0];
                end
                lfsp_pkg::REG_THR_MID_LEFT: begin
                    r_cfg.thr_mid_left <= i_wr_data[lfsp_pkg::SENSE_W-1:0];
                end
                lfsp_pkg::REG_THR_MID_RIGHT: begin
                    r_cfg.thr_mid_right <= i_wr_data[lfsp_pkg::SENSE_W-1:0];
                end
                lfsp_pkg::REG_THR_FAR_RIGHT: begin
                    r_cfg.thr_far_right <= i_wr_data[lfsp_pkg::SENSE_W-1:0];
                end
                lfsp_pkg::REG_BASE_SPEED: begin
                    r_cfg.base_speed <= i_wr_data[lfsp_pkg::SPEED_W-1:0];
                end
                lfsp_pkg::REG_KI_GAIN: begin
                    r_cfg.ki_gain <= i_wr_data[lfsp_pkg::KI_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/lfsp_mac.sv =====
// ============================================================================
// lfsp_mac
// Shared signed multiplier with a registered product and an accumulator.
// Under the sequencer's step code it forms kp, kd and then the sum
// kp*e + ki*sum + kd*de in Q20.
// ============================================================================
`default_nettype none

module lfsp_mac (
    input  wire logic                                   i_clk,
    input  wire lfsp_pkg::t_mac_ctrl                    i_ctrl,
    input  wire logic        [lfsp_pkg::SENSE_W-1:0]    i_avg,
    input  wire logic signed [lfsp_pkg::ERR_W-1:0]      i_err,
    input  wire logic signed [lfsp_pkg::DERR_W-1:0]     i_derr,
    input  wire logic signed [lfsp_pkg::SUM_W-1:0]      i_err_sum,
    input  wire logic        [lfsp_pkg::KI_W-1:0]       i_ki,
    output logic signed      [lfsp_pkg::ACC_W-1:0]      o_acc
);

    localparam int OW = lfsp_pkg::OPND_W;

    logic signed [lfsp_pkg::ERR_W-1:0]  w_span;
    logic signed [OW-1:0]               w_opnd_a;
    logic signed [OW-1:0]               w_opnd_b;
    logic signed [lfsp_pkg::PROD_W-1:0] w_prod;

    logic signed [lfsp_pkg::ACC_W-1:0]  r_prod;
    logic signed [lfsp_pkg::KP_W-1:0]   r_kp;
    logic signed [lfsp_pkg::KD_W-1:0]   r_kd;
    logic signed [lfsp_pkg::ACC_W-1:0]  r_acc;

    // Distance of the center average from full scale; negative above it.
    assign w_span = $signed({1'b0, lfsp_pkg::FULL_SCALE} - {1'b0, i_avg});

    // Operand selection for each step.
    always_comb begin
        w_opnd_a = '0;
        w_opnd_b = '0;
        case (i_ctrl.step)
            lfsp_pkg::STEP_KP: begin
                w_opnd_a = $signed({{(OW-10){1'b0}}, lfsp_pkg::KP_SCALE});
                w_opnd_b = {{(OW-lfsp_pkg::ERR_W){w_span[lfsp_pkg::ERR_W-1]}}, w_span};
            end
            lfsp_pkg::STEP_KD: begin
                w_opnd_a = $signed({{(OW-4){1'b0}}, lfsp_pkg::KD_FACTOR});
                w_opnd_b = r_prod[OW-1:0];
            end
            lfsp_pkg::STEP_P: begin
                w_opnd_a = {{(OW-lfsp_pkg::KP_W){r_kp[lfsp_pkg::KP_W-1]}}, r_kp};
                w_opnd_b = {{(OW-lfsp_pkg::ERR_W){i_err[lfsp_pkg::ERR_W-1]}}, i_err};
            end
            lfsp_pkg::STEP_I: begin
                w_opnd_a = $signed({{(OW-lfsp_pkg::KI_W){1'b0}}, i_ki});
                w_opnd_b = {{(OW-lfsp_pkg::SUM_W){i_err_sum[lfsp_pkg::SUM_W-1]}},
                            i_err_sum};
            end
            lfsp_pkg::STEP_D: begin
                w_opnd_a = {{(OW-lfsp_pkg::KD_W){r_kd[lfsp_pkg::KD_W-1]}}, r_kd};
                w_opnd_b = {{(OW-lfsp_pkg::DERR_W){i_derr[lfsp_pkg::DERR_W-1]}},
                            i_derr};
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_opnd_a * w_opnd_b;

    // Product register, gain registers and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.run) begin
            r_prod <= w_prod[lfsp_pkg::ACC_W-1:0];
            case (i_ctrl.step)
                lfsp_pkg::STEP_KD: begin
                    r_kp <= r_prod[lfsp_pkg::KP_W-1:0];
                end
                lfsp_pkg::STEP_P: begin
                    r_kd <= r_prod[lfsp_pkg::KD_W-1:0];
                end
                lfsp_pkg::STEP_I: begin
                    r_acc <= r_prod;
                end
                lfsp_pkg::STEP_D, lfsp_pkg::STEP_LAST: begin
                    r_acc <= r_acc + r_prod;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== design/lfsp_checker.sv =====
// ============================================================================
// lfsp_checker
// Port-level checks for the line-follow steering PID unit, bound to the
// top level.
// ============================================================================
`default_nettype none

module lfsp_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [lfsp_pkg::SPEED_W-1:0]       o_left_speed,
    input wire logic [lfsp_pkg::SPEED_W-1:0]       o_right_speed,
    input wire logic [lfsp_pkg::MODE_W-1:0]        o_steer_mode,
    input wire logic                               o_cfg_ready
);

    // The unit works on one beat at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a beat is in flight");

    // An extreme-left result stops the left motor.
    a_ext_left_stops_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_steer_mode == lfsp_pkg::MODE_EXT_LEFT) |-> (o_left_speed == '0))
        else $error("extreme-left result with nonzero left speed");

    // An extreme-right result stops the right motor.
    a_ext_right_stops_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_steer_mode == lfsp_pkg::MODE_EXT_RIGHT) |-> (o_right_speed == '0))
        else $error("extreme-right result with nonzero right speed");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_left_speed) && $stable(o_right_speed) &&
             $stable(o_steer_mode)))
        else $error("result beat changed while stalled");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind line_follow_steering_pid_unit lfsp_checker u_lfsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_steer_mode  (o_steer_mode),
    .o_cfg_ready   (o_cfg_ready)
);

`default_nettype wire
